@@ hdl/twma_pkg.sv @@
// Types and constants shared by the time-weighted moving average block.
// No dependencies; compiled before the interfaces and the top level.
`default_nettype none

package twma_pkg;

  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned NOW_W     = 32;
  localparam int unsigned AVG_W     = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP  = 1'b1;

  localparam logic [CFG_W-1:0] DURATION_RST = 16'd1000;
  localparam logic [CFG_W-1:0] MAX_GAP_RST  = 16'd10000;

  // rate quotient is a non-negative Q16.16 value: 31 magnitude bits
  localparam int unsigned RATE_W   = 31;
  localparam logic [RATE_W-1:0] RATE_MAX = 31'h7FFF_FFFF;
  // sample * 1000 fits in 31 + 10 bits
  localparam int unsigned NUM_W    = RATE_W + 10;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [0:0] OP_PLAIN = 1'b0;
  localparam logic [0:0] OP_RATE  = 1'b1;

endpackage

`default_nettype wire

@@ hdl/twma_ifs.sv @@
// Valid/ready channel interfaces for the input items and the result items.
// Depends on twma_pkg for the field widths.
`default_nettype none

interface twma_in_if import twma_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [NOW_W-1:0]           now_ms;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, operation, now_ms, sample, input ready);
  modport sink   (input valid, operation, now_ms, sample, output ready);
endinterface

interface twma_out_if import twma_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [AVG_W-1:0] average;
  logic             accepted;

  modport source (output valid, average, accepted, input ready);
  modport sink   (input valid, average, accepted, output ready);
endinterface

`default_nettype wire

@@ hdl/time_weighted_moving_average.sv @@
// Time-weighted exponential moving average, top level.
// Depends on twma_pkg and the channel interfaces in twma_ifs.sv.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------
//  in_i     | in  | valid/ready        | operation, now_ms, sample
//  out_o    | out | valid/ready        | average, accepted
//  cfg      | in  | cfg_we_i, no stall | cfg_idx_i, cfg_data_i
//
// Steps per item: PREP, CHECK, then FIN at once for an ignored item; else RDIV,
// the per-second divide for rate items (skipped when the rate saturates), WSET,
// WDIV, the weight divide (skipped at weight one), MUL1, MUL2, ADD and FIN.
// Both divides run one quotient bit a cycle through one shared compare/subtract
// unit, and one shared multiplier forms both blend products.
// in_i is ready only in IDLE; the result sits in an output register, so the
// next item is taken while it waits, but that item holds in FIN until the
// waiting result is taken. Async active-low reset clears the state, and the
// registers return to duration 1000 ms and max gap 10000 ms.
`default_nettype none

module time_weighted_moving_average import twma_pkg::*; #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  twma_in_if.sink                   in_i,
  twma_out_if.source                out_o
);

  localparam int unsigned WGT_W  = FRAC_BITS + 1;
  localparam int unsigned PROD_W = AVG_W + WGT_W;
  localparam int unsigned ACC_W  = PROD_W + 1;
  localparam logic [WGT_W-1:0] WgtOne = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_CHECK, ST_RDIV, ST_WSET, ST_WDIV,
    ST_MUL1, ST_MUL2, ST_ADD, ST_FIN
  } state_e;

  state_e                 state_q;
  logic [CFG_W-1:0]       duration_q, max_gap_q;
  logic [TIME_BITS-1:0]   last_q;
  logic [AVG_W-1:0]       avg_q;
  logic                   op_q;
  logic [NOW_W-1:0]       now_q;
  logic [SAMPLE_W-1:0]    sample_q;
  logic [CFG_W-1:0]       elapsed_q;
  logic                   ok_q;
  logic [NUM_W-1:0]       num_q;
  logic [RATE_W-1:0]      num_sh_q;
  logic [CFG_W-1:0]       rem_q, divisor_q;
  logic [RATE_W-1:0]      quot_q;
  logic [DIV_CNT_W-1:0]   cnt_q;
  logic [RATE_W-1:0]      x_q;
  logic [WGT_W-1:0]       w_q;
  logic [PROD_W-1:0]      prod_q;
  logic [ACC_W-1:0]       acc_q;
  logic                   out_valid_q;
  logic [AVG_W-1:0]       out_avg_q;
  logic                   out_acc_q;

  // elapsed time, clamped
  logic [63:0]          now64;
  logic [TIME_BITS-1:0] now_t, diff;
  logic [CFG_W-1:0]     elapsed_d;
  logic                 ok_d;
  logic [NUM_W-1:0]     num_d;

  always_comb begin
    now64 = {32'b0, now_q};
    now_t = now64[TIME_BITS-1:0];
    diff  = now_t - last_q;
    if (diff[TIME_BITS-1]) begin
      elapsed_d = '0;
    end else if (diff > TIME_BITS'(max_gap_q)) begin
      elapsed_d = max_gap_q;
    end else begin
      elapsed_d = diff[CFG_W-1:0];
    end
    ok_d  = !sample_q[SAMPLE_W-1] && !(op_q == OP_RATE && elapsed_d == '0);
    // sample * 1000 = sample * (1024 - 16 - 8)
    num_d = {sample_q[RATE_W-1:0], 10'b0}
          - {6'b0, sample_q[RATE_W-1:0], 4'b0}
          - {7'b0, sample_q[RATE_W-1:0], 3'b0};
  end

  // shared restoring divide step
  logic [CFG_W:0]    rem_sh;
  logic              div_ge;
  logic [CFG_W-1:0]  rem_nx;
  logic [RATE_W-1:0] quot_nx;

  always_comb begin
    rem_sh  = {rem_q, (state_q == ST_RDIV) ? num_sh_q[RATE_W-1] : 1'b0};
    div_ge  = rem_sh >= {1'b0, divisor_q};
    rem_nx  = div_ge ? CFG_W'(rem_sh - {1'b0, divisor_q}) : rem_sh[CFG_W-1:0];
    quot_nx = {quot_q[RATE_W-2:0], div_ge};
  end

  // shared multiplier
  logic [AVG_W-1:0]  mul_a;
  logic [WGT_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod_d;

  always_comb begin
    if (state_q == ST_MUL1) begin
      mul_a = avg_q;
      mul_b = WgtOne - w_q;
    end else begin
      mul_a = {1'b0, x_q};
      mul_b = w_q;
    end
    prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  logic out_free;
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready     = (state_q == ST_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.average  = out_avg_q;
  assign out_o.accepted = out_acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      duration_q  <= DURATION_RST;
      max_gap_q   <= MAX_GAP_RST;
      last_q      <= '0;
      avg_q       <= '0;
      op_q        <= 1'b0;
      now_q       <= '0;
      sample_q    <= '0;
      elapsed_q   <= '0;
      ok_q        <= 1'b0;
      num_q       <= '0;
      num_sh_q    <= '0;
      rem_q       <= '0;
      divisor_q   <= '0;
      quot_q      <= '0;
      cnt_q       <= '0;
      x_q         <= '0;
      w_q         <= '0;
      prod_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_avg_q   <= '0;
      out_acc_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DURATION: duration_q <= cfg_data_i;
          CFG_MAX_GAP:  max_gap_q  <= cfg_data_i;
          default:      ;
        endcase
      end

      // FIN refills the output register itself when it is taken
      if (out_valid_q && out_o.ready && state_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            op_q     <= in_i.operation;
            now_q    <= in_i.now_ms;
            sample_q <= in_i.sample;
            state_q  <= ST_PREP;
          end
        end
        ST_PREP: begin
          elapsed_q <= elapsed_d;
          ok_q      <= ok_d;
          num_q     <= num_d;
          state_q   <= ST_CHECK;
        end
        ST_CHECK: begin
          if (!ok_q) begin
            state_q <= ST_FIN;
          end else if (op_q == OP_RATE) begin
            // quotient would pass the rate limit
            if (CFG_W'(num_q[NUM_W-1:RATE_W]) >= elapsed_q) begin
              x_q     <= RATE_MAX;
              state_q <= ST_WSET;
            end else begin
              rem_q     <= CFG_W'(num_q[NUM_W-1:RATE_W]);
              num_sh_q  <= num_q[RATE_W-1:0];
              divisor_q <= elapsed_q;
              cnt_q     <= DIV_CNT_W'(RATE_W);
              state_q   <= ST_RDIV;
            end
          end else begin
            x_q     <= sample_q[RATE_W-1:0];
            state_q <= ST_WSET;
          end
        end
        ST_RDIV: begin
          rem_q    <= rem_nx;
          quot_q   <= quot_nx;
          num_sh_q <= {num_sh_q[RATE_W-2:0], 1'b0};
          cnt_q    <= cnt_q - DIV_CNT_W'(1);
          if (cnt_q == DIV_CNT_W'(1)) begin
            x_q     <= quot_nx;
            state_q <= ST_WSET;
          end
        end
        ST_WSET: begin
          // weight saturates at one once the gap reaches the duration, or when the duration is zero
          if (duration_q == '0 || elapsed_q >= duration_q) begin
            w_q     <= WgtOne;
            state_q <= ST_MUL1;
          end else begin
            rem_q     <= elapsed_q;
            divisor_q <= duration_q;
            cnt_q     <= DIV_CNT_W'(FRAC_BITS);
            state_q   <= ST_WDIV;
          end
        end
        ST_WDIV: begin
          rem_q  <= rem_nx;
          quot_q <= quot_nx;
          cnt_q  <= cnt_q - DIV_CNT_W'(1);
          if (cnt_q == DIV_CNT_W'(1)) begin
            w_q     <= {1'b0, quot_nx[FRAC_BITS-1:0]};
            state_q <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          prod_q  <= prod_d;
          state_q <= ST_MUL2;
        end
        ST_MUL2: begin
          acc_q   <= {1'b0, prod_q};
          prod_q  <= prod_d;
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          acc_q   <= acc_q + {1'b0, prod_q};
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_acc_q   <= ok_q;
            if (ok_q) begin
              avg_q     <= acc_q[FRAC_BITS +: AVG_W];
              out_avg_q <= acc_q[FRAC_BITS +: AVG_W];
              last_q    <= now_t;
            end else begin
              out_avg_q <= avg_q;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/time_weighted_moving_average_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for time_weighted_moving_average: directed and random items,
// checked against an in-bench predictor of the weighted average.
// Depends on twma_pkg, twma_ifs.sv and the top level; needs no other file.

module time_weighted_moving_average_tb;
  import twma_pkg::*;

  localparam int unsigned FRAC_BITS    = 16;
  localparam logic [63:0] ONE_Q        = 64'd1 << FRAC_BITS;
  localparam logic [63:0] MS_PER_SEC   = 64'd1000;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES  = 64;

  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic             accepted;
  } avg_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  twma_in_if  in_ch ();
  twma_out_if out_ch ();

  time_weighted_moving_average uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state and register copies
  logic [CFG_W-1:0] cfg_duration = DURATION_RST;
  logic [CFG_W-1:0] cfg_max_gap  = MAX_GAP_RST;
  logic [NOW_W-1:0] model_last_ms = '0;
  logic [AVG_W-1:0] model_avg     = '0;

  avg_result_t      expected_avg_q[$];
  logic [NOW_W-1:0] clock_ms = '0;
  bit               gaps_on  = 1'b1;
  int unsigned      error_count = 0;
  int unsigned      idle_cycles = 0;

  task automatic flag_error(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Advances the predictor by one item and returns the result it must produce.
  function automatic avg_result_t predict_average(logic op, logic [NOW_W-1:0] now,
                                                  logic [SAMPLE_W-1:0] raw);
    logic [NOW_W-1:0] delta;
    logic [63:0]      gap;
    logic [63:0]      w;
    logic [63:0]      x;
    logic [63:0]      acc;
    avg_result_t      r;
    delta = now - model_last_ms;
    gap = delta[NOW_W-1] ? 64'd0 : {32'd0, delta};
    if (gap > {48'd0, cfg_max_gap}) gap = {48'd0, cfg_max_gap};
    r.accepted = !raw[SAMPLE_W-1] && !(op == OP_RATE && gap == 64'd0);
    if (r.accepted) begin
      x = {32'd0, raw};
      if (op == OP_RATE) begin
        x = (x * MS_PER_SEC) / gap;
        if (x > {33'd0, RATE_MAX}) x = {33'd0, RATE_MAX};
      end
      if (cfg_duration == '0) begin
        w = ONE_Q;
      end else begin
        w = (gap << FRAC_BITS) / {48'd0, cfg_duration};
        if (w > ONE_Q) w = ONE_Q;
      end
      acc = {32'd0, model_avg} * (ONE_Q - w) + x * w;
      model_avg = acc[FRAC_BITS +: AVG_W];
      model_last_ms = now;
    end
    r.average = model_avg;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken,
  // leaving valid up so the caller's next step decides what it carries.
  task automatic send_item(logic op, logic [NOW_W-1:0] now, logic [SAMPLE_W-1:0] raw);
    int unsigned hold;
    if (gaps_on && $urandom_range(0, 99) < 37) begin
      hold = $urandom_range(1, 70);
      in_ch.valid = 1'b0;
      repeat (hold) @(negedge clk_i);
    end
    in_ch.valid     = 1'b1;
    in_ch.operation = op;
    in_ch.now_ms    = now;
    in_ch.sample    = raw;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_avg_q.push_back(predict_average(op, now, raw));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    wait (expected_avg_q.size() == 0);
    @(negedge clk_i);
  endtask

  // only called with the block idle
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_DURATION) cfg_duration = value;
    else cfg_max_gap = value;
  endtask

  function automatic logic [CFG_W-1:0] pick_register_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3, 4, 5: return 16'($urandom_range(1, 3000));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_item();
    logic                op;
    logic [SAMPLE_W-1:0] raw;
    op = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 19))
      0:         clock_ms = $urandom;
      1:         clock_ms = clock_ms - $urandom_range(1, 4000);
      2, 3:      ;  // same timestamp again
      4, 5, 6:   clock_ms = clock_ms + $urandom_range(1, 16);
      7:         clock_ms = clock_ms + $urandom_range(60000, 200000);
      default:   clock_ms = clock_ms + $urandom_range(1, 2 * int'(cfg_duration) + 2);
    endcase
    case ($urandom_range(0, 15))
      0, 1:    raw = {1'b1, 31'($urandom)};
      2:       raw = 32'h7FFF_FFFF;
      3:       raw = '0;
      4, 5, 6: raw = $urandom_range(0, 32'h0003_FFFF);
      default: raw = {1'b0, 31'($urandom >> $urandom_range(0, 30))};
    endcase
    send_item(op, clock_ms, raw);
  endtask

  // reset registers, state starts at zero time and zero average
  task automatic test_directed_defaults();
    send_item(OP_PLAIN, 32'd0,    32'h0001_0000);  // no time passed: weight zero
    send_item(OP_PLAIN, 32'd500,  32'h7FFF_FFFF);  // half weight
    send_item(OP_PLAIN, 32'd1500, 32'h0001_0000);  // full weight
    send_item(OP_PLAIN, 32'd1600, 32'h8000_0000);  // negative, ignored
    send_item(OP_RATE,  32'd1600, 32'hFFFF_FFFF);  // negative rate, ignored
    send_item(OP_RATE,  32'd1500, 32'h0004_0000);  // rate with no time passed
    send_item(OP_RATE,  32'd1501, 32'h7FFF_FFFF);  // 1 ms: rate saturates
    send_item(OP_RATE,  32'd1751, 32'h0002_0000);
    send_item(OP_PLAIN, 32'd1000, 32'h0003_0000);  // time went back, still taken
    send_item(OP_RATE,  32'd900,  32'h0003_0000);  // back again, rate ignored
    send_item(OP_PLAIN, 32'd80000, 32'h0000_0001); // gap clamped to max
    send_item(OP_PLAIN, 32'hFFFF_FFF0, 32'h0);     // huge difference reads negative
    send_item(OP_RATE,  32'h0000_0010, 32'h0001_0000); // counter wraps
    send_item(OP_PLAIN, 32'h8000_0010, 32'h1234_5678); // difference exactly 2^31
    send_item(OP_PLAIN, 32'h8000_03F8, 32'h7FFF_FFFF);
    send_item(OP_RATE,  32'h8000_2B08, 32'h0);
    send_item(OP_RATE,  32'h8000_5219, 32'h7FFF_FFFF);
    drain_results();
  endtask

  task automatic test_register_extremes();
    write_register(CFG_DURATION, 16'h0000);  // weight always one
    write_register(CFG_MAX_GAP,  16'hFFFF);
    send_item(OP_PLAIN, clock_ms + 32'd3, 32'h0000_ABCD);
    send_item(OP_RATE,  clock_ms + 32'd7, 32'h0010_0000);
    send_item(OP_PLAIN, clock_ms + 32'd7, 32'hC000_0000);
    drain_results();
    write_register(CFG_MAX_GAP, 16'h0000);   // elapsed always zero
    send_item(OP_PLAIN, clock_ms + 32'd50, 32'h0055_0000);
    send_item(OP_RATE,  clock_ms + 32'd90, 32'h0066_0000);
    drain_results();
    write_register(CFG_DURATION, 16'hFFFF);
    write_register(CFG_MAX_GAP,  16'hFFFF);
    clock_ms = clock_ms + 32'd200000;
    send_item(OP_PLAIN, clock_ms, 32'h7FFF_FFFF);
    clock_ms = clock_ms + 32'd70000;
    send_item(OP_RATE,  clock_ms, 32'h7FFF_FFFF);
    clock_ms = clock_ms + 32'd100;
    send_item(OP_PLAIN, clock_ms, 32'h0000_0001);
    drain_results();
    write_register(CFG_DURATION, 16'd1);
    write_register(CFG_MAX_GAP,  16'd1);
    clock_ms = clock_ms + 32'd1;
    send_item(OP_PLAIN, clock_ms, 32'h0200_0000);
    clock_ms = clock_ms + 32'd5;
    send_item(OP_RATE,  clock_ms, 32'h0400_0000);
    drain_results();
  endtask

  task automatic test_random_phase(int unsigned n_items, bit with_gaps);
    write_register(CFG_DURATION, pick_register_value());
    write_register(CFG_MAX_GAP,  pick_register_value());
    gaps_on = with_gaps;
    repeat (n_items) send_random_item();
    drain_results();
    gaps_on = 1'b1;
  endtask

  task automatic finish_run();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  endtask

  // result side: ready changes at the falling edge
  always @(negedge clk_i) begin
    out_ch.ready = !gaps_on || ($urandom_range(0, 99) >= 37);
  end

  always @(posedge clk_i) begin : result_check
    avg_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_avg_q.size() == 0) begin
        flag_error("result with nothing pending, average", out_ch.average, '0);
      end else begin
        want = expected_avg_q.pop_front();
        if (out_ch.average !== want.average)
          flag_error("average", out_ch.average, want.average);
        if (out_ch.accepted !== want.accepted)
          flag_error("accepted", {31'd0, out_ch.accepted}, {31'd0, want.accepted});
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_DURATION;
    cfg_data_i      = '0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_PLAIN;
    in_ch.now_ms    = '0;
    in_ch.sample    = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_defaults();
    test_register_extremes();
    test_random_phase(100, 1'b1);
    test_random_phase(100, 1'b1);
    test_random_phase(100, 1'b1);
    test_random_phase(120, 1'b0);  // long stretch, both sides always ready
    test_random_phase(100, 1'b1);
    finish_run();
  end

endmodule
